FILE: rtl/sdip_pkg.sv
package sdip_pkg;

  // byte classes seen by the back end
  localparam logic [2:0] CLS_BLANK = 3'd0;
  localparam logic [2:0] CLS_MINUS = 3'd1;
  localparam logic [2:0] CLS_PLUS  = 3'd2;
  localparam logic [2:0] CLS_DIGIT = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_WORDS = 2'd2;
  localparam logic [1:0] ST_END_ONLY = 2'd3;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       sep;
    logic [2:0] cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

endpackage

FILE: rtl/sdip_front.sv
module sdip_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [7:0]      cfg_data,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  output sdip_pkg::token_t token
);
  import sdip_pkg::*;

  logic [7:0] separator;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= 8'd32;
    end else if (cfg_valid) begin
      separator <= cfg_data;
    end
  end

  // classify one byte
  always_comb begin
    token.sep   = (text_byte == separator);
    token.last  = end_of_text;
    token.digit = 4'(text_byte - 8'd48);
    if (text_byte >= 8'd48 && text_byte <= 8'd57) begin
      token.cls = CLS_DIGIT;
    end else if ((text_byte >= 8'd9 && text_byte <= 8'd13) || text_byte == 8'd32) begin
      token.cls = CLS_BLANK;
    end else if (text_byte == 8'd45) begin
      token.cls = CLS_MINUS;
    end else if (text_byte == 8'd43) begin
      token.cls = CLS_PLUS;
    end else begin
      token.cls = CLS_OTHER;
    end
  end

endmodule

FILE: rtl/sdip_queue.sv
module sdip_queue #(
  parameter int unsigned DEPTH = sdip_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sdip_pkg::token_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output sdip_pkg::token_t pop_data
);
  import sdip_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  token_t          entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sdip_back.sv
module sdip_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  sdip_pkg::token_t   tok,
  output logic               tok_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] number,
  output logic [1:0]         status,
  output logic               final_result
);
  import sdip_pkg::*;

  localparam logic [1:0] PH_BLANKS = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic        word_open, word_open_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic        negative, negative_next;
  logic [31:0] magnitude, magnitude_next;
  logic        overflowed, overflowed_next;
  logic        any_word_seen, any_word_seen_next;

  logic        emit;
  logic [31:0] emit_number;
  logic [1:0]  emit_status;
  logic        take;
  logic [35:0] times_ten;
  logic [35:0] limit;

  assign tok_pop = tok_valid && (!out_valid || out_ready);

  always_comb begin
    word_open_next     = word_open;
    parse_phase_next   = parse_phase;
    negative_next      = negative;
    magnitude_next     = magnitude;
    overflowed_next    = overflowed;
    any_word_seen_next = any_word_seen;
    emit        = 1'b0;
    emit_number = '0;
    emit_status = ST_OK;
    take        = 1'b0;

    if (!tok.sep) begin
      // open a word on its first byte
      if (!word_open) begin
        word_open_next     = 1'b1;
        parse_phase_next   = PH_BLANKS;
        negative_next      = 1'b0;
        magnitude_next     = '0;
        overflowed_next    = 1'b0;
        any_word_seen_next = 1'b1;
      end
      case (parse_phase_next)
        PH_BLANKS: begin
          case (tok.cls)
            CLS_BLANK: ;
            CLS_MINUS: begin
              negative_next    = 1'b1;
              parse_phase_next = PH_DIGITS;
            end
            CLS_PLUS:  parse_phase_next = PH_DIGITS;
            CLS_DIGIT: begin
              parse_phase_next = PH_DIGITS;
              take             = 1'b1;
            end
            default:   parse_phase_next = PH_DONE;
          endcase
        end
        PH_DIGITS: begin
          if (tok.cls == CLS_DIGIT) begin
            take = 1'b1;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    // magnitude * 10 + digit, checked against the sign's limit
    times_ten = {1'b0, magnitude_next, 3'b000} + {3'b000, magnitude_next, 1'b0}
              + {32'd0, tok.digit};
    limit = negative_next ? 36'h0_8000_0000 : 36'h0_7fff_ffff;
    if (take && !overflowed_next) begin
      if (times_ten > limit) begin
        overflowed_next = 1'b1;
      end else begin
        magnitude_next = times_ten[31:0];
      end
    end

    // close the word or mark the end of text
    if ((!tok.sep && tok.last) || (tok.sep && word_open)) begin
      emit = 1'b1;
      if (overflowed_next) begin
        emit_status = ST_OVERFLOW;
      end else begin
        emit_number = negative_next ? 32'd0 - magnitude_next : magnitude_next;
      end
      word_open_next   = 1'b0;
      parse_phase_next = PH_BLANKS;
      negative_next    = 1'b0;
      magnitude_next   = '0;
      overflowed_next  = 1'b0;
    end else if (tok.sep && tok.last) begin
      emit        = 1'b1;
      emit_status = any_word_seen ? ST_END_ONLY : ST_NO_WORDS;
    end

    if (tok.last) begin
      word_open_next     = 1'b0;
      parse_phase_next   = PH_BLANKS;
      negative_next      = 1'b0;
      magnitude_next     = '0;
      overflowed_next    = 1'b0;
      any_word_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_open     <= 1'b0;
      parse_phase   <= PH_BLANKS;
      negative      <= 1'b0;
      magnitude     <= '0;
      overflowed    <= 1'b0;
      any_word_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (tok_pop) begin
        word_open     <= word_open_next;
        parse_phase   <= parse_phase_next;
        negative      <= negative_next;
        magnitude     <= magnitude_next;
        overflowed    <= overflowed_next;
        any_word_seen <= any_word_seen_next;
        out_valid     <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      number       <= emit_number;
      status       <= emit_status;
      final_result <= tok.last;
    end
  end

endmodule

FILE: rtl/separated_decimal_int_parser_core.sv
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  separator
// in        in         in_valid/in_ready    text_byte, end_of_text
// out       out        out_valid/out_ready  number, status, final_result
//
// one byte a cycle while in_ready is high; a byte is queued and its result registered
// (classify into the queue, then one multiply-by-ten, add and compare step)
// reset is synchronous on rst; separator returns to 32, all parse state clears
// in_ready drops only when the token queue is full, out_ready low stalls the back end
module separated_decimal_int_parser_core #(
  parameter int unsigned QUEUE_DEPTH = sdip_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         separator,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] number,
  output logic [1:0]         status,
  output logic               final_result
);
  import sdip_pkg::*;

  token_t front_token;
  token_t back_token;
  logic   queue_full;
  logic   queue_not_empty;
  logic   queue_pop;

  // separator register write is always taken
  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;

  // front: separator register and byte classifier
  sdip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (separator),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .token       (front_token)
  );

  // short queue of classified bytes between front and back
  sdip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !queue_full),
    .push_data (front_token),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_data  (back_token)
  );

  // back: word state, digit accumulation, result register
  sdip_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (queue_not_empty),
    .tok          (back_token),
    .tok_pop      (queue_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .number       (number),
    .status       (status),
    .final_result (final_result)
  );

endmodule
